// ===== rtl/ccrq_pkg.sv =====
// ----------------------------------------------------------------------------
// ccrq_pkg: shared types and constants
// Register map, reset values, configuration bundle and the queue item that
// passes from the pick logic to the quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ccrq_pkg;

  // field widths
  localparam int DIM_W       = 12;
  localparam int GAIN_W      = 24;
  localparam int BIAS_W      = 32;
  localparam int PIX_W       = 8;
  localparam int CHANNELS    = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_WIDTH    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_HEIGHT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_QUANT_GAIN   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_QUANT_BIAS   = 3'd5;

  // reset values
  localparam logic [DIM_W-1:0]  RESET_FRAME_WIDTH  = 12'd320;
  localparam logic [DIM_W-1:0]  RESET_FRAME_HEIGHT = 12'd240;
  localparam logic [DIM_W-1:0]  RESET_OUT_WIDTH    = 12'd96;
  localparam logic [DIM_W-1:0]  RESET_OUT_HEIGHT   = 12'd96;
  localparam logic [GAIN_W-1:0] RESET_QUANT_GAIN   = 24'd65536;
  localparam logic [BIAS_W-1:0] RESET_QUANT_BIAS   = 32'd0;

  // saturation limits of the int8 result
  localparam int QUANT_MIN = -128;
  localparam int QUANT_MAX = 127;

  typedef struct packed {
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic [DIM_W-1:0]  out_width;
    logic [DIM_W-1:0]  out_height;
    logic [GAIN_W-1:0] quant_gain;
    logic [BIAS_W-1:0] quant_bias;
  } cfg_t;

  typedef struct packed {
    logic             bad_size;
    logic             end_of_frame;
    logic             end_of_row;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/ccrq_front.sv =====
// ----------------------------------------------------------------------------
// ccrq_front: crop and pick logic
// Tracks the source position, decides per pixel whether it is picked for the
// downscaled square and pushes picked pixels (or a bad-size flag) to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ccrq_front #(
  parameter int MAX_DIM = 2048
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ccrq_pkg::cfg_t             cfg,
  input  wire logic                       hold,
  input  wire logic                       pix_valid,
  output logic                            pix_ready,
  input  wire logic                       start_of_frame,
  input  wire logic [ccrq_pkg::PIX_W-1:0] red,
  input  wire logic [ccrq_pkg::PIX_W-1:0] green,
  input  wire logic [ccrq_pkg::PIX_W-1:0] blue,
  input  wire logic                       q_ready,
  output logic                            q_push,
  output ccrq_pkg::item_t                 q_item
);

  localparam int CW = $clog2(MAX_DIM + 1);
  localparam int PW = 2 * CW;
  localparam int XW = (CW > ccrq_pkg::DIM_W) ? CW : ccrq_pkg::DIM_W;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_DIM);

  function automatic logic dim_ok(input logic [XW-1:0] d);
    return (d != '0) && (d <= MAX_X);
  endfunction

  // size checks and crop geometry, widened so oversize values compare right
  logic [XW-1:0] fw_x, fh_x, ow_x, oh_x, side_x;
  logic          bad_x;

  always_comb begin
    fw_x   = XW'(cfg.frame_width);
    fh_x   = XW'(cfg.frame_height);
    ow_x   = XW'(cfg.out_width);
    oh_x   = XW'(cfg.out_height);
    side_x = (fw_x < fh_x) ? fw_x : fh_x;
    bad_x  = !dim_ok(fw_x) || !dim_ok(fh_x) || !dim_ok(ow_x) || !dim_ok(oh_x) ||
             (ow_x > side_x) || (oh_x > side_x);
  end

  // geometry registers, refreshed every cycle from the config
  logic [CW-1:0] d_fw, d_fh, d_ow, d_oh, d_side, d_x0, d_x0_end, d_y0, d_y0_end;
  logic          d_bad;
  logic [CW-1:0] fw_c, fh_c, side_c, x0_c, y0_c;

  always_comb begin
    fw_c   = fw_x[CW-1:0];
    fh_c   = fh_x[CW-1:0];
    side_c = side_x[CW-1:0];
    x0_c   = (fw_c - side_c) >> 1;
    y0_c   = (fh_c - side_c) >> 1;
  end

  always_ff @(posedge clk) begin
    d_fw     <= fw_c;
    d_fh     <= fh_c;
    d_ow     <= ow_x[CW-1:0];
    d_oh     <= oh_x[CW-1:0];
    d_side   <= side_c;
    d_x0     <= x0_c;
    d_x0_end <= x0_c + side_c;
    d_y0     <= y0_c;
    d_y0_end <= y0_c + side_c;
    d_bad    <= bad_x;
  end

  // position counters
  logic [CW-1:0] source_column, source_row, output_column, output_row;
  logic [PW-1:0] column_product, row_product;
  logic          row_is_picked;
  logic [CW-1:0] source_column_next, source_row_next, output_column_next, output_row_next;
  logic [PW-1:0] column_product_next, row_product_next;
  logic          row_is_picked_next;

  // counters as seen by this pixel: a frame start clears them first
  logic [CW-1:0] e_sc, e_sr, e_oc, e_or;
  logic [PW-1:0] e_cp, e_rp;
  logic          e_rip;

  logic          accept;
  logic [CW-1:0] row_rel, col_rel, oc_inc;
  logic [PW-1:0] row_lim, col_lim;
  logic [CW:0]   or_inc;
  logic          row_in, row_pick, col_in, hit, eor, eof, end_col, end_frame;

  assign pix_ready = q_ready && !hold;
  assign accept    = pix_valid && pix_ready;

  always_comb begin
    e_sc  = start_of_frame ? '0 : source_column;
    e_sr  = start_of_frame ? '0 : source_row;
    e_oc  = start_of_frame ? '0 : output_column;
    e_or  = start_of_frame ? '0 : output_row;
    e_cp  = start_of_frame ? '0 : column_product;
    e_rp  = start_of_frame ? '0 : row_product;
    e_rip = start_of_frame ? 1'b0 : row_is_picked;

    // row pick, decided at the first column of each source row
    row_rel  = e_sr - d_y0 + 1'b1;
    row_lim  = PW'(row_rel) * PW'(d_oh);
    row_in   = (e_sr >= d_y0) && (e_sr < d_y0_end) && (e_or < d_oh);
    row_pick = (e_sc == '0) ? (row_in && (e_rp < row_lim)) : e_rip;

    // column pick
    col_rel = e_sc - d_x0 + 1'b1;
    col_lim = PW'(col_rel) * PW'(d_ow);
    col_in  = row_pick && (e_sc >= d_x0) && (e_sc < d_x0_end) && (e_oc < d_ow);
    hit     = col_in && (e_cp < col_lim);

    // row and frame end marks of the output
    oc_inc = e_oc + 1'b1;
    or_inc = {1'b0, e_or} + 1'b1;
    eor    = oc_inc >= d_ow;
    eof    = eor && (or_inc >= {1'b0, d_oh});

    end_col   = (e_sc + 1'b1) >= d_fw;
    end_frame = (e_sr + 1'b1) >= d_fh;
  end

  // counter update
  always_comb begin
    source_column_next  = source_column;
    source_row_next     = source_row;
    output_column_next  = output_column;
    output_row_next     = output_row;
    column_product_next = column_product;
    row_product_next    = row_product;
    row_is_picked_next  = row_is_picked;
    if (accept) begin
      priority if (d_bad) begin
        source_column_next  = '0;
        source_row_next     = '0;
        output_column_next  = '0;
        output_row_next     = '0;
        column_product_next = '0;
        row_product_next    = '0;
        row_is_picked_next  = 1'b0;
      end else if (end_col) begin
        source_column_next  = '0;
        output_column_next  = '0;
        column_product_next = '0;
        row_is_picked_next  = 1'b0;
        if (end_frame) begin
          source_row_next  = '0;
          output_row_next  = '0;
          row_product_next = '0;
        end else begin
          source_row_next  = e_sr + 1'b1;
          output_row_next  = row_pick ? or_inc[CW-1:0] : e_or;
          row_product_next = row_pick ? (e_rp + PW'(d_side)) : e_rp;
        end
      end else begin
        source_column_next  = e_sc + 1'b1;
        source_row_next     = e_sr;
        output_column_next  = hit ? oc_inc : e_oc;
        column_product_next = hit ? (e_cp + PW'(d_side)) : e_cp;
        output_row_next     = e_or;
        row_product_next    = e_rp;
        row_is_picked_next  = row_pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_column  <= '0;
      source_row     <= '0;
      output_column  <= '0;
      output_row     <= '0;
      column_product <= '0;
      row_product    <= '0;
      row_is_picked  <= 1'b0;
    end else begin
      source_column  <= source_column_next;
      source_row     <= source_row_next;
      output_column  <= output_column_next;
      output_row     <= output_row_next;
      column_product <= column_product_next;
      row_product    <= row_product_next;
      row_is_picked  <= row_is_picked_next;
    end
  end

  // queue item
  always_comb begin
    q_push = accept && (d_bad ? start_of_frame : hit);
    q_item = '0;
    if (d_bad) begin
      q_item.bad_size = 1'b1;
    end else begin
      q_item.red          = red;
      q_item.green        = green;
      q_item.blue         = blue;
      q_item.end_of_row   = eor;
      q_item.end_of_frame = eof;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ccrq_fifo.sv =====
// ----------------------------------------------------------------------------
// ccrq_fifo: short queue
// Flop-based first-in first-out buffer between the pick logic and the
// quantizer, so either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module ccrq_fifo #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  in_ready,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  out_valid
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [NW-1:0] FULL = NW'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [NW-1:0]    count;
  logic             do_push, do_pop;

  assign in_ready  = count != FULL;
  assign out_valid = count != '0;
  assign dout      = slots[rd_ptr];
  assign do_push   = push && in_ready;
  assign do_pop    = pop && out_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ccrq_quant.sv =====
// ----------------------------------------------------------------------------
// ccrq_quant: int8 quantizer
// Three-stage pipeline: channel times gain, plus bias, then round half away
// from zero and saturate to int8, or zero for a bad-size item. Ends in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccrq_quant (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [ccrq_pkg::GAIN_W-1:0] quant_gain,
  input  wire logic [ccrq_pkg::BIAS_W-1:0] quant_bias,
  input  wire logic                        q_valid,
  output logic                             q_pop,
  input  wire ccrq_pkg::item_t             q_item,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [ccrq_pkg::PIX_W-1:0]       quant_red,
  output logic [ccrq_pkg::PIX_W-1:0]       quant_green,
  output logic [ccrq_pkg::PIX_W-1:0]       quant_blue,
  output logic                             end_of_row,
  output logic                             end_of_frame,
  output logic                             bad_size
);

  localparam int NCH  = ccrq_pkg::CHANNELS;
  localparam int PRW  = ccrq_pkg::PIX_W + ccrq_pkg::GAIN_W;
  localparam int VW   = PRW + 2;
  localparam int QW   = VW - 16;
  localparam logic signed [QW-1:0] Q_MIN = QW'(ccrq_pkg::QUANT_MIN);
  localparam logic signed [QW-1:0] Q_MAX = QW'(ccrq_pkg::QUANT_MAX);

  // round half away from zero in Q18.16, then clamp to int8
  function automatic logic [ccrq_pkg::PIX_W-1:0] round_sat(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] r;
    logic signed [QW-1:0] q;
    logic [ccrq_pkg::PIX_W-1:0] res;
    r = v + (v[VW-1] ? VW'(32767) : VW'(32768));
    q = r[VW-1:16];
    if (q < Q_MIN) begin
      res = Q_MIN[ccrq_pkg::PIX_W-1:0];
    end else if (q > Q_MAX) begin
      res = Q_MAX[ccrq_pkg::PIX_W-1:0];
    end else begin
      res = q[ccrq_pkg::PIX_W-1:0];
    end
    return res;
  endfunction

  logic [ccrq_pkg::PIX_W-1:0] pix [NCH];
  assign pix[0] = q_item.red;
  assign pix[1] = q_item.green;
  assign pix[2] = q_item.blue;

  // stage registers
  logic                        s1_valid, s2_valid;
  logic [PRW-1:0]              s1_prod [NCH];
  logic signed [VW-1:0]        s2_sum  [NCH];
  logic [ccrq_pkg::PIX_W-1:0]  o_q     [NCH];
  logic [2:0]                  s1_flags, s2_flags, o_flags;
  logic                        en1, en2, en_out;

  // stall chain from the output back to the queue
  assign en_out = !out_valid || out_ready;
  assign en2    = !s2_valid || en_out;
  assign en1    = !s1_valid || en2;
  assign q_pop  = q_valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= q_valid;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
      if (en_out) begin
        out_valid <= s2_valid;
      end
    end
  end

  // multiply, add bias, round and saturate
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int c = 0; c < NCH; c++) begin
        s1_prod[c] <= PRW'(pix[c]) * PRW'(quant_gain);
      end
      s1_flags <= {q_item.bad_size, q_item.end_of_frame, q_item.end_of_row};
    end
    if (en2) begin
      for (int c = 0; c < NCH; c++) begin
        s2_sum[c] <= $signed({2'b00, s1_prod[c]}) +
                     $signed({{(VW - ccrq_pkg::BIAS_W){quant_bias[ccrq_pkg::BIAS_W-1]}},
                              quant_bias});
      end
      s2_flags <= s1_flags;
    end
    if (en_out) begin
      for (int c = 0; c < NCH; c++) begin
        o_q[c] <= s2_flags[2] ? '0 : round_sat(s2_sum[c]);
      end
      o_flags <= s2_flags;
    end
  end

  assign quant_red    = o_q[0];
  assign quant_green  = o_q[1];
  assign quant_blue   = o_q[2];
  assign end_of_row   = o_flags[0];
  assign end_of_frame = o_flags[1];
  assign bad_size     = o_flags[2];

endmodule

`default_nettype wire

// ===== rtl/center_crop_resize_quantize.sv =====
// ----------------------------------------------------------------------------
// center_crop_resize_quantize: crop, downscale and int8 quantizer
// Center-crops an RGB raster stream to a square, picks pixels by
// nearest-neighbor downscaling and quantizes each channel to int8.
// ----------------------------------------------------------------------------
// Takes one source pixel per clock in raster order and emits the picked
// pixels as three saturated int8 values, round(channel*gain + bias) with
// Q8.16 gain and Q16.16 bias. The pick decision for a pixel is made in the
// cycle it is accepted, by the counter and compare loop of the front end, so
// the sustained input rate is one pixel per clock. An accepted pixel is
// written into the queue, passes through the quantizer stages s1 and s2
// into the output register and transfers once the output is ready.
// The input pauses in the cycle after every configuration write, while the
// crop geometry registers reload, and whenever the queue (QUEUE_DEPTH
// entries) fills under output back-pressure. A configuration that is out of
// range or asks for upscaling holds all counters at zero and answers each
// start-of-frame pixel with a bad-size result.
// ----------------------------------------------------------------------------
`default_nettype none

module center_crop_resize_quantize #(
  parameter int MAX_DIM     = 2048,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // source pixels
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [23:0]                      s_tdata,   // red, green, blue
  input  wire logic [0:0]                       s_tuser,   // start_of_frame
  // quantized pixels
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [23:0]                           m_tdata,   // quant_red, quant_green, quant_blue
  output logic                                  m_tlast,   // end_of_row
  output logic [1:0]                            m_tuser,   // end_of_frame, bad_size
  // configuration writes
  input  wire logic                             cfg_write,
  input  wire logic [ccrq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ccrq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int ITEM_W = $bits(ccrq_pkg::item_t);

  ccrq_pkg::cfg_t  cfg;
  logic            cfg_settle;
  logic            q_push, q_ready, q_valid, q_pop;
  ccrq_pkg::item_t q_in, q_out;
  logic [ITEM_W-1:0] q_out_bits;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= ccrq_pkg::RESET_FRAME_WIDTH;
      cfg.frame_height <= ccrq_pkg::RESET_FRAME_HEIGHT;
      cfg.out_width    <= ccrq_pkg::RESET_OUT_WIDTH;
      cfg.out_height   <= ccrq_pkg::RESET_OUT_HEIGHT;
      cfg.quant_gain   <= ccrq_pkg::RESET_QUANT_GAIN;
      cfg.quant_bias   <= ccrq_pkg::RESET_QUANT_BIAS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ccrq_pkg::REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[ccrq_pkg::DIM_W-1:0];
        ccrq_pkg::REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[ccrq_pkg::DIM_W-1:0];
        ccrq_pkg::REG_OUT_WIDTH:    cfg.out_width    <= cfg_data[ccrq_pkg::DIM_W-1:0];
        ccrq_pkg::REG_OUT_HEIGHT:   cfg.out_height   <= cfg_data[ccrq_pkg::DIM_W-1:0];
        ccrq_pkg::REG_QUANT_GAIN:   cfg.quant_gain   <= cfg_data[ccrq_pkg::GAIN_W-1:0];
        ccrq_pkg::REG_QUANT_BIAS:   cfg.quant_bias   <= cfg_data[ccrq_pkg::BIAS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // hold the input in the cycle after a write, while geometry reloads
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_settle <= 1'b1;
    end else begin
      cfg_settle <= cfg_write;
    end
  end

  ccrq_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .hold           (cfg_settle),
    .pix_valid      (s_tvalid),
    .pix_ready      (s_tready),
    .start_of_frame (s_tuser[0]),
    .red            (s_tdata[7:0]),
    .green          (s_tdata[15:8]),
    .blue           (s_tdata[23:16]),
    .q_ready        (q_ready),
    .q_push         (q_push),
    .q_item         (q_in)
  );

  ccrq_fifo #(
    .WIDTH(ITEM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .din       (q_in),
    .in_ready  (q_ready),
    .pop       (q_pop),
    .dout      (q_out_bits),
    .out_valid (q_valid)
  );

  assign q_out = q_out_bits;

  ccrq_quant u_quant (
    .clk          (clk),
    .rst          (rst),
    .quant_gain   (cfg.quant_gain),
    .quant_bias   (cfg.quant_bias),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_out),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .quant_red    (m_tdata[7:0]),
    .quant_green  (m_tdata[15:8]),
    .quant_blue   (m_tdata[23:16]),
    .end_of_row   (m_tlast),
    .end_of_frame (m_tuser[0]),
    .bad_size     (m_tuser[1])
  );

  // a bad-size result carries nothing else
  a_bad_size_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tlast && !m_tuser[0])
    else $error("bad-size result with nonzero payload");

  // the last pixel of a frame also ends its row
  a_eof_is_eor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("end of frame without end of row");

  // no pixel transfer right after a configuration write
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> !s_tready)
    else $error("pixel accepted while geometry reloads");

  // the pick logic never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_ready)
    else $error("queue overflow");

endmodule

`default_nettype wire
